// ===== design/mcme_pkg.sv =====
// Shared types, codes and helper functions for the cursor mask expander.
// No dependencies; imported by every module of the block.
package mcme_pkg;

    // 2-bit pixel codes held in the row store
    localparam logic [1:0] CODE_T = 2'd0;   // transparent
    localparam logic [1:0] CODE_B = 2'd1;   // black
    localparam logic [1:0] CODE_W = 2'd2;   // white

    localparam logic [31:0] ARGB_CLEAR = 32'h0000_0000;
    localparam logic [31:0] ARGB_BLACK = 32'hFF00_0000;
    localparam logic [31:0] ARGB_WHITE = 32'hFFFF_FFFF;

    // shape_mode values
    localparam logic [1:0] MODE_MONO   = 2'd0;
    localparam logic [1:0] MODE_COLOR  = 2'd1;
    localparam logic [1:0] MODE_MASKED = 2'd2;

    // configuration register indexes
    localparam logic CFG_SHAPE_MODE = 1'b0;
    localparam logic CFG_ROW_BYTES  = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] COUNT_MONO  = 4'd8;
    localparam logic [3:0] COUNT_COLOR = 4'd1;

    typedef enum logic {
        KIND_MONO,
        KIND_COLOR
    } item_kind_t;

    // one classified input item as handed from front to back
    typedef struct packed {
        item_kind_t  kind;
        logic        last;
        logic [31:0] color;  // colour modes: pixel after masking
        logic [15:0] word;   // mono: codes with in-byte left darkening applied
        logic [7:0]  inv;    // mono: inverse pixels, bit i = pixel i from the left
    } item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MONO,
        ST_FLUSH_RD,
        ST_FLUSH_OUT
    } back_state_t;

    // turn transparent codes black where the mask bit is set
    function automatic logic [15:0] fix_word(input logic [15:0] word, input logic [7:0] mask);
        logic [15:0] res;
        res = word;
        for (int i = 0; i < 8; i++) begin
            if (mask[i] && (word[2*i +: 2] == CODE_T)) begin
                res[2*i +: 2] = CODE_B;
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] code_to_argb(input logic [1:0] code);
        logic [31:0] res;
        priority if (code == CODE_T) begin
            res = ARGB_CLEAR;
        end
        else if (code == CODE_B) begin
            res = ARGB_BLACK;
        end
        else begin
            res = ARGB_WHITE;
        end
        return res;
    endfunction

endpackage

// ===== design/mcme_front.sv =====
// Front end: configuration registers, input handshake and item classification.
// Depends on mcme_pkg; feeds mcme_queue.
module mcme_front #(
    parameter int MAX_ROW_BYTES = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic                                   cfg_index,
    input  logic [5:0]                             cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [7:0]                             and_byte,
    input  logic [7:0]                             xor_byte,
    input  logic [31:0]                            color_pixel,
    input  logic                                   last_item,
    input  logic                                   q_full,
    output logic                                   q_push,
    output mcme_pkg::item_t                        q_item,
    output logic [((MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1):0] rb
);
    import mcme_pkg::*;

    localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int RB_W  = COL_W + 1;

    logic [1:0] shape_mode_reg, shape_mode_next;
    logic [5:0] row_bytes_reg, row_bytes_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        shape_mode_next = shape_mode_reg;
        row_bytes_next  = row_bytes_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SHAPE_MODE: shape_mode_next = cfg_data[1:0];
                CFG_ROW_BYTES:  row_bytes_next  = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            shape_mode_reg <= MODE_MONO;
            row_bytes_reg  <= 6'd4;
        end
        else begin
            shape_mode_reg <= shape_mode_next;
            row_bytes_reg  <= row_bytes_next;
        end
    end

    // row width clamped to 1..MAX_ROW_BYTES
    always_comb
    begin
        priority if (row_bytes_reg == 6'd0) begin
            rb = RB_W'(1);
        end
        else if (row_bytes_reg > 6'(MAX_ROW_BYTES)) begin
            rb = RB_W'(MAX_ROW_BYTES);
        end
        else begin
            rb = RB_W'(row_bytes_reg);
        end
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // classification
    always_comb
    begin
        logic [1:0] base [8];
        logic [7:0] inv;
        logic       a;
        logic       x;
        for (int i = 0; i < 8; i++) begin
            a       = and_byte[7 - i];
            x       = xor_byte[7 - i];
            inv[i]  = a && x;
            base[i] = x ? CODE_W : (a ? CODE_T : CODE_B);
        end
        q_item.word = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < 7 && base[i] == CODE_T && inv[(i + 1) % 8]) begin
                q_item.word[2*i +: 2] = CODE_B;
            end
            else begin
                q_item.word[2*i +: 2] = base[i];
            end
        end
        q_item.inv  = inv;
        q_item.last = last_item;
        q_item.kind = (shape_mode_reg == MODE_MONO) ? KIND_MONO : KIND_COLOR;
        if (shape_mode_reg == MODE_MASKED && color_pixel[31:24] != 8'd0) begin
            q_item.color = ARGB_CLEAR;
        end
        else begin
            q_item.color = color_pixel;
        end
    end

endmodule

// ===== design/mcme_queue.sv =====
// Two-entry item queue between front and back end.
// Depends on mcme_pkg for the item type.
module mcme_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mcme_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            pop_valid,
    output mcme_pkg::item_t pop_item
);
    import mcme_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/mcme_back.sv =====
// Back end: row store, row sequencing, end-of-image flush and output register.
// Depends on mcme_pkg; fed by mcme_queue.
module mcme_back #(
    parameter int MAX_ROW_BYTES = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_valid,
    input  mcme_pkg::item_t                        q_item,
    output logic                                   q_pop,
    input  logic [((MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1):0] rb,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [7:0][31:0]                       out_pix,
    output logic [3:0]                             out_count,
    output logic                                   out_last
);
    import mcme_pkg::*;

    localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int RB_W  = COL_W + 1;
    localparam int MEM_D = 2 * MAX_ROW_BYTES;
    localparam int AW    = $clog2(MEM_D);

    back_state_t      state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             first_row_reg, first_row_next;
    logic             bank_reg, bank_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [15:0]      pend_word_reg, pend_word_next;
    logic [AW-1:0]    pend_addr_reg, pend_addr_next;
    item_t            cur_reg, cur_next;
    logic             byp_reg, byp_next;
    logic [15:0]      byp_word_reg, byp_word_next;
    logic             flush_prv_reg, flush_prv_next;
    logic [COL_W-1:0] fcol_reg, fcol_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0][31:0] out_pix_reg, out_pix_next;
    logic [3:0]       out_count_reg, out_count_next;
    logic             out_last_reg, out_last_next;

    logic [15:0]      row_mem [MEM_D];
    logic [15:0]      rd_data_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [15:0]      mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    logic             out_free;
    logic [AW-1:0]    cur_base;
    logic [AW-1:0]    prv_base;
    logic [AW-1:0]    addr_prv;
    logic [AW-1:0]    addr_cur;
    logic [AW-1:0]    addr_flush;
    logic [RB_W-1:0]  col_inc;
    logic [RB_W-1:0]  fcol_inc;
    logic             row_done;
    logic             flush_at_pend;
    logic [15:0]      left_word;
    logic [15:0]      top_word;
    logic [15:0]      flush_word;

    assign out_free      = !out_valid_reg || !out_stall;
    assign cur_base      = bank_reg ? AW'(MAX_ROW_BYTES) : '0;
    assign prv_base      = bank_reg ? '0 : AW'(MAX_ROW_BYTES);
    assign addr_prv      = prv_base + AW'(col_reg);
    assign addr_cur      = cur_base + AW'(col_reg);
    assign addr_flush    = (flush_prv_reg ? prv_base : cur_base) + AW'(fcol_reg);
    assign col_inc       = RB_W'(col_reg) + RB_W'(1);
    assign fcol_inc      = RB_W'(fcol_reg) + RB_W'(1);
    assign row_done      = (col_inc >= rb);
    assign flush_at_pend = !flush_prv_reg && (fcol_reg == col_reg);
    // an inverse leftmost pixel darkens the rightmost pixel of the byte to its left
    assign left_word     = fix_word(pend_word_reg, {q_item.inv[0] && (col_reg != '0), 7'd0});
    assign top_word      = fix_word(byp_reg ? byp_word_reg : rd_data_reg, cur_reg.inv);
    assign flush_word    = flush_at_pend ? pend_word_reg : rd_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_item.kind == KIND_MONO) begin
                    state_next = ST_MONO;
                end
            end
            ST_MONO:
            begin
                if (first_row_reg || out_free) begin
                    state_next = cur_reg.last ? ST_FLUSH_RD : ST_IDLE;
                end
            end
            ST_FLUSH_RD:
            begin
                state_next = ST_FLUSH_OUT;
            end
            ST_FLUSH_OUT:
            begin
                if (out_free) begin
                    state_next = flush_at_pend ? ST_IDLE : ST_FLUSH_RD;
                end
            end
        endcase
    end

    // datapath and store control
    always_comb
    begin
        col_next        = col_reg;
        first_row_next  = first_row_reg;
        bank_next       = bank_reg;
        pend_valid_next = pend_valid_reg;
        pend_word_next  = pend_word_reg;
        pend_addr_next  = pend_addr_reg;
        cur_next        = cur_reg;
        byp_next        = byp_reg;
        byp_word_next   = byp_word_reg;
        flush_prv_next  = flush_prv_reg;
        fcol_next       = fcol_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_pix_next    = out_pix_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = addr_prv;
        mem_wdata       = top_word;
        mem_re          = 1'b0;
        mem_raddr       = addr_prv;
        q_pop           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid) begin
                    if (q_item.kind == KIND_COLOR) begin
                        if (out_free) begin
                            q_pop          = 1'b1;
                            out_valid_next = 1'b1;
                            out_pix_next   = '0;
                            out_pix_next[0] = q_item.color;
                            out_count_next = COUNT_COLOR;
                            out_last_next  = q_item.last;
                            if (q_item.last) begin
                                col_next       = '0;
                                first_row_next = 1'b1;
                                bank_next      = 1'b0;
                            end
                        end
                    end
                    else begin
                        // read the byte above; retire the held byte to its left
                        q_pop    = 1'b1;
                        cur_next = q_item;
                        mem_re   = 1'b1;
                        if (pend_valid_reg) begin
                            mem_we    = 1'b1;
                            mem_waddr = pend_addr_reg;
                            mem_wdata = left_word;
                        end
                        pend_valid_next = 1'b0;
                        byp_next        = pend_valid_reg && (pend_addr_reg == addr_prv);
                        byp_word_next   = left_word;
                    end
                end
            end
            ST_MONO:
            begin
                if (first_row_reg || out_free) begin
                    if (!first_row_reg) begin
                        mem_we         = 1'b1;
                        out_valid_next = 1'b1;
                        out_count_next = COUNT_MONO;
                        out_last_next  = 1'b0;
                        for (int i = 0; i < 8; i++) begin
                            out_pix_next[i] = code_to_argb(top_word[2*i +: 2]);
                        end
                    end
                    pend_valid_next = 1'b1;
                    pend_word_next  = cur_reg.word;
                    pend_addr_next  = addr_cur;
                    if (cur_reg.last) begin
                        if (!first_row_reg && !row_done) begin
                            flush_prv_next = 1'b1;
                            fcol_next      = COL_W'(col_inc);
                        end
                        else begin
                            flush_prv_next = 1'b0;
                            fcol_next      = '0;
                        end
                    end
                    else if (row_done) begin
                        col_next       = '0;
                        first_row_next = 1'b0;
                        bank_next      = ~bank_reg;
                    end
                    else begin
                        col_next = COL_W'(col_inc);
                    end
                end
            end
            ST_FLUSH_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = addr_flush;
            end
            ST_FLUSH_OUT:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_count_next = COUNT_MONO;
                    out_last_next  = flush_at_pend;
                    for (int i = 0; i < 8; i++) begin
                        out_pix_next[i] = code_to_argb(flush_word[2*i +: 2]);
                    end
                    if (flush_prv_reg) begin
                        if (fcol_inc >= rb) begin
                            flush_prv_next = 1'b0;
                            fcol_next      = '0;
                        end
                        else begin
                            fcol_next = COL_W'(fcol_inc);
                        end
                    end
                    else if (flush_at_pend) begin
                        mem_we          = 1'b1;
                        mem_waddr       = pend_addr_reg;
                        mem_wdata       = pend_word_reg;
                        pend_valid_next = 1'b0;
                        col_next        = '0;
                        first_row_next  = 1'b1;
                        bank_next       = 1'b0;
                    end
                    else begin
                        fcol_next = COL_W'(fcol_inc);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            row_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= row_mem[mem_raddr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_word_reg <= pend_word_next;
        pend_addr_reg <= pend_addr_next;
        cur_reg       <= cur_next;
        byp_word_reg  <= byp_word_next;
        out_pix_reg   <= out_pix_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            col_reg        <= '0;
            first_row_reg  <= 1'b1;
            bank_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            byp_reg        <= 1'b0;
            flush_prv_reg  <= 1'b0;
            fcol_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            first_row_reg  <= first_row_next;
            bank_reg       <= bank_next;
            pend_valid_reg <= pend_valid_next;
            byp_reg        <= byp_next;
            flush_prv_reg  <= flush_prv_next;
            fcol_reg       <= fcol_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;
    assign out_count = out_count_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== design/mono_cursor_mask_expand.sv =====
// mono_cursor_mask_expand: pointer shape to 32-bit ARGB expander (top level).
// Depends on mcme_pkg, mcme_front, mcme_queue and mcme_back.
//
// Input channel (in_valid / in_stall): one transfer per mask byte pair or colour
// pixel; last_item marks the end of the image. Output channel (out_valid /
// out_stall): one transfer per result, eight pixels in monochrome mode with
// pixel_count 8, one pixel in pixel_a with pixel_count 1 in the colour modes.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 shape_mode,
// index 1 row_bytes; write only while the block is idle.
// In the back end a colour item goes straight to the output register; a
// monochrome byte takes a read of the row store, then the update of the byte
// above and its release, before the next item is taken. On last_item in
// monochrome mode the rest of the image is flushed from the row store, each
// result by a read then an output step, up to row_bytes results. Input items
// reach the output through the two-entry queue and the output register.
// Reset empties the queue and output register, selects monochrome mode with
// 4 bytes per row and starts a fresh image; the row store is not cleared.
// A stalled output holds its result; the back end waits while the queue keeps
// taking input until full, after which in_stall is raised.
module mono_cursor_mask_expand #(
    parameter int MAX_ROW_BYTES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  and_byte,
    input  logic [7:0]  xor_byte,
    input  logic [31:0] color_pixel,
    input  logic        last_item,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] pixel_a,
    output logic [31:0] pixel_b,
    output logic [31:0] pixel_c,
    output logic [31:0] pixel_d,
    output logic [31:0] pixel_e,
    output logic [31:0] pixel_f,
    output logic [31:0] pixel_g,
    output logic [31:0] pixel_h,
    output logic [3:0]  pixel_count,
    output logic        last_result
);
    import mcme_pkg::*;

    localparam int COL_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int RB_W  = COL_W + 1;

    item_t            push_item;
    item_t            pop_item;
    logic             q_push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic [RB_W-1:0]  rb;
    logic [7:0][31:0] out_pix;

    // front end: config registers, handshake and classification
    mcme_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .and_byte    (and_byte),
        .xor_byte    (xor_byte),
        .color_pixel (color_pixel),
        .last_item   (last_item),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item),
        .rb          (rb)
    );

    // decouples input acceptance from the row sequencer
    mcme_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (pop_item)
    );

    // back end: row store, flush and output register
    mcme_back #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (pop_item),
        .q_pop     (q_pop),
        .rb        (rb),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_pix   (out_pix),
        .out_count (pixel_count),
        .out_last  (last_result)
    );

    assign pixel_a = out_pix[0];
    assign pixel_b = out_pix[1];
    assign pixel_c = out_pix[2];
    assign pixel_d = out_pix[3];
    assign pixel_e = out_pix[4];
    assign pixel_f = out_pix[5];
    assign pixel_g = out_pix[6];
    assign pixel_h = out_pix[7];

endmodule
